>>> hw/rtl/sonar_wall_follow_controller_top_macros.svh
// assertion helpers used by swf_core
`ifndef SONAR_WALL_FOLLOW_CONTROLLER_TOP_MACROS_SVH
`define SONAR_WALL_FOLLOW_CONTROLLER_TOP_MACROS_SVH

// same-cycle implication, checked out of reset
`define SWF_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("swf check failed");

// next-cycle implication, checked out of reset
`define SWF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("swf check failed");

`endif

>>> hw/rtl/swf_pkg.sv
package swf_pkg;

  typedef struct packed {
    logic [9:0] front_dist;
    logic [9:0] left_dist;
    logic [9:0] right_dist;
  } swf_in_t;

  typedef struct packed {
    logic [2:0]  motion_mode;
    logic [12:0] step_count;
  } swf_out_t;

  typedef struct packed {
    logic [11:0] left_turn_step_count;
    logic [11:0] right_turn_step_count;
    logic [9:0]  front_clearance;
    logic [9:0]  side_clearance;
  } swf_cfg_t;

  typedef enum logic [2:0] {
    PH_NORMAL = 3'd0,
    PH_WAIT1  = 3'd1,
    PH_WAIT2  = 3'd2,
    PH_DECIDE = 3'd3,
    PH_ALIGN  = 3'd4
  } swf_phase_t;

  localparam logic [2:0] MODE_FORWARD = 3'd1;
  localparam logic [2:0] MODE_LEFT    = 3'd3;
  localparam logic [2:0] MODE_RIGHT   = 3'd4;
  localparam logic [2:0] MODE_SHIFT_L = 3'd5;
  localparam logic [2:0] MODE_SHIFT_R = 3'd6;
  localparam logic [2:0] MODE_ALIGN   = 3'd7;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 12;
  localparam logic [CFG_IDX_W-1:0] CFG_LEFT_TURN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_TURN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRONT_CLR  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SIDE_CLR   = 2'd3;

  localparam logic [11:0] RST_LEFT_TURN  = 12'd1150;
  localparam logic [11:0] RST_RIGHT_TURN = 12'd1150;
  localparam logic [9:0]  RST_FRONT_CLR  = 10'd20;
  localparam logic [9:0]  RST_SIDE_CLR   = 10'd40;

  localparam int CNT_W = 20;
  localparam logic [CNT_W-1:0] RST_ALIGN_CNT = 20'd999999;
  localparam logic [1:0] COOL_RELOAD = 2'd2;

endpackage

>>> hw/rtl/swf_cfg.sv
module swf_cfg
  import swf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  cfg_ready,
  output swf_cfg_t              regs
);

  swf_cfg_t regs_r;
  swf_cfg_t regs_nxt;

  assign cfg_ready = 1'b1;
  assign regs = regs_r;

  always_comb begin
    regs_nxt = regs_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_LEFT_TURN:  regs_nxt.left_turn_step_count = cfg_data;
        CFG_RIGHT_TURN: regs_nxt.right_turn_step_count = cfg_data;
        CFG_FRONT_CLR:  regs_nxt.front_clearance = cfg_data[9:0];
        CFG_SIDE_CLR:   regs_nxt.side_clearance = cfg_data[9:0];
        default:        regs_nxt = regs_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.left_turn_step_count <= RST_LEFT_TURN;
      regs_r.right_turn_step_count <= RST_RIGHT_TURN;
      regs_r.front_clearance <= RST_FRONT_CLR;
      regs_r.side_clearance <= RST_SIDE_CLR;
    end else begin
      regs_r <= regs_nxt;
    end
  end

endmodule

>>> hw/rtl/swf_core.sv
`include "sonar_wall_follow_controller_top_macros.svh"

module swf_core
  import swf_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     adv,
  input  swf_in_t  item,
  input  swf_cfg_t regs,
  output logic     res_valid,
  output swf_out_t res
);

  swf_phase_t       phase_r, phase_nxt;
  logic [1:0]       cool_r, cool_nxt;
  logic [CNT_W-1:0] valid_cnt_r, valid_cnt_nxt;
  logic [CNT_W-1:0] align_cnt_r, align_cnt_nxt;

  logic [9:0]       f, l, r;
  logic [10:0]      total;
  logic [9:0]       diff;
  logic [9:0]       f_off;
  logic [8:0]       cmd;
  logic             calib;
  logic             shift_hit;
  logic [3:0]       near;
  logic [9:0]       shift_raw;
  logic [9:0]       shift_lim;
  logic [9:0]       shift;
  logic [CNT_W-1:0] valid_base;

  function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                               input logic [9:0] b);
    logic [CNT_W:0] s;
    s = {1'b0, a} + {{(CNT_W-9){1'b0}}, b};
    return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
  endfunction

  assign f = item.front_dist;
  assign l = item.left_dist;
  assign r = item.right_dist;
  assign total = {1'b0, l} + {1'b0, r};
  assign diff = (l > r) ? (l - r) : (r - l);
  assign f_off = f - 10'd10;

  // speed from front range, clamped; front of exactly ten gives zero
  always_comb begin
    if (f < 10'd10) begin
      cmd = 9'd20;
    end else if (f >= 10'd35) begin
      cmd = 9'd500;
    end else begin
      cmd = 9'({4'd0, f_off[4:0]} * 9'd20);
    end
  end

  assign calib = (total < 11'd35) && ((total > 11'd30) || (diff > 10'd3)) &&
                 (valid_cnt_r > 20'd2000) && (align_cnt_r > 20'd4000) &&
                 (f > 10'd40) && ((l <= 10'd15) || (r <= 10'd15));

  assign shift_hit = ({1'b0, f} > ({1'b0, regs.front_clearance} + 11'd5)) &&
                     ((r < 10'd11) || (l < 10'd11));
  assign near = (r < 10'd11) ? r[3:0] : l[3:0];
  assign shift_raw = 10'({6'd0, 4'd11 - near} * 10'd50);
  assign shift_lim = {cmd, 1'b0};
  assign shift = (shift_raw > shift_lim) ? shift_lim : shift_raw;

  assign valid_base = (total >= 11'd35) ? '0 : valid_cnt_r;

  always_comb begin
    phase_nxt = phase_r;
    cool_nxt = cool_r;
    valid_cnt_nxt = valid_cnt_r;
    align_cnt_nxt = align_cnt_r;
    res_valid = 1'b0;
    res.motion_mode = MODE_FORWARD;
    res.step_count = '0;
    case (phase_r)
      PH_WAIT1: phase_nxt = PH_WAIT2;
      PH_WAIT2: phase_nxt = PH_DECIDE;
      PH_DECIDE: begin
        phase_nxt = PH_NORMAL;
        cool_nxt = COOL_RELOAD;
        if (l > 10'd25) begin
          res_valid = 1'b1;
          res.motion_mode = MODE_LEFT;
          res.step_count = {1'b0, regs.left_turn_step_count};
        end else if (r > 10'd25) begin
          res_valid = 1'b1;
          res.motion_mode = MODE_RIGHT;
          res.step_count = {1'b0, regs.right_turn_step_count};
        end else if ((total > 11'd30) || (diff > 10'd3)) begin
          // drive clear, then align on the next word
          res_valid = 1'b1;
          res.motion_mode = MODE_FORWARD;
          res.step_count = 13'd500;
          phase_nxt = PH_ALIGN;
          cool_nxt = cool_r;
        end
      end
      PH_ALIGN: begin
        phase_nxt = PH_NORMAL;
        cool_nxt = COOL_RELOAD;
        res_valid = 1'b1;
        res.motion_mode = MODE_ALIGN;
        res.step_count = 13'd500;
      end
      default: begin
        phase_nxt = PH_NORMAL;
        valid_cnt_nxt = valid_base;
        if (calib) begin
          valid_cnt_nxt = '0;
          align_cnt_nxt = '0;
          res_valid = 1'b1;
          res.motion_mode = MODE_ALIGN;
          res.step_count = {1'b0, regs.left_turn_step_count};
        end else if (shift_hit) begin
          valid_cnt_nxt = sat_add(valid_base, shift);
          align_cnt_nxt = sat_add(align_cnt_r, shift);
          res_valid = 1'b1;
          res.motion_mode = (r < 10'd11) ? MODE_SHIFT_L : MODE_SHIFT_R;
          res.step_count = {3'd0, shift};
        end else if (f > regs.front_clearance) begin
          valid_cnt_nxt = sat_add(valid_base, {1'b0, cmd});
          align_cnt_nxt = sat_add(align_cnt_r, {1'b0, cmd});
          res_valid = 1'b1;
          res.motion_mode = MODE_FORWARD;
          res.step_count = {4'd0, cmd};
        end else if ((l > regs.side_clearance) || (r > regs.side_clearance)) begin
          if (cool_r == 2'd0) begin
            cool_nxt = COOL_RELOAD;
            res_valid = 1'b1;
            if (l > regs.side_clearance) begin
              res.motion_mode = MODE_LEFT;
              res.step_count = {1'b0, regs.left_turn_step_count};
            end else begin
              res.motion_mode = MODE_RIGHT;
              res.step_count = {1'b0, regs.right_turn_step_count};
            end
          end else begin
            cool_nxt = cool_r - 2'd1;
          end
        end else if (cool_r == 2'd0) begin
          // turn-around: double left turn, then wait out two words before deciding
          phase_nxt = PH_WAIT1;
          res_valid = 1'b1;
          res.motion_mode = MODE_LEFT;
          res.step_count = {regs.left_turn_step_count, 1'b0};
        end else begin
          cool_nxt = cool_r - 2'd1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_NORMAL;
      cool_r <= '0;
      valid_cnt_r <= '0;
      align_cnt_r <= RST_ALIGN_CNT;
    end else if (adv) begin
      phase_r <= phase_nxt;
      cool_r <= cool_nxt;
      valid_cnt_r <= valid_cnt_nxt;
      align_cnt_r <= align_cnt_nxt;
    end
  end

  `SWF_ASSERT_NOW(a_wait_silent,
                  adv && (phase_r == PH_WAIT1 || phase_r == PH_WAIT2), !res_valid)
  `SWF_ASSERT_NEXT(a_align_returns, adv && phase_r == PH_ALIGN,
                   phase_r == PH_NORMAL && cool_r == COOL_RELOAD)
  `SWF_ASSERT_NEXT(a_decide_fwd,
                   adv && phase_r == PH_DECIDE && res_valid && res.motion_mode == MODE_FORWARD,
                   phase_r == PH_ALIGN)
  `SWF_ASSERT_NEXT(a_calib_clears,
                   adv && phase_r == PH_NORMAL && res_valid && res.motion_mode == MODE_ALIGN,
                   valid_cnt_r == '0 && align_cnt_r == '0)

endmodule

>>> hw/rtl/sonar_wall_follow_controller_top.sv
// Sonar wall-follow controller: each input word is a front/left/right sonar triple and gives at
// most one stepper command (motion mode and step count) on the output. One word is taken per
// clock unless the input side stalls: the input register feeds a single decision stage that
// reads and updates the controller state (phase, turn cooldown and the two saturating step
// counters) and writes the output register in the same cycle, so a command passes from the input
// register through the decision stage into the output register. The input side stalls only while
// the output register holds a command the downstream side has not taken. Configuration writes are
// always ready and should be issued only while no word is in flight.
module sonar_wall_follow_controller_top
  import swf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  swf_in_t               in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output swf_out_t              out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic     in_valid_r;
  swf_in_t  in_data_r;
  logic     out_valid_r;
  swf_out_t out_data_r;
  logic     adv;
  logic     accept;
  logic     res_valid;
  swf_out_t res;
  swf_cfg_t regs;

  // decision stage moves when it holds a word and the output register is free or being drained
  assign adv = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !adv;
  assign accept = in_valid && !in_stall;

  assign out_valid = out_valid_r;
  assign out_data = out_data_r;

  swf_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_ready (cfg_ready),
    .regs      (regs)
  );

  swf_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .item      (in_data_r),
    .regs      (regs),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (accept) begin
      in_valid_r <= 1'b1;
    end else if (adv) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_data_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= res_valid;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res_valid) begin
      out_data_r <= res;
    end
  end

endmodule
